FILE: sv/kwm_pkg.sv
package kwm_pkg;

   // Field widths of the request and response payloads.
   localparam int VALUE_BITS       = 30;
   localparam int RUN_BITS         = 4;
   localparam int CSR_BITS         = 5;

   // Default number of head entries and the run count after reset.
   localparam int MAX_RUNS_DEFAULT = 16;
   localparam logic [CSR_BITS-1:0] RUN_COUNT_RESET = CSR_BITS'(10);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  run_empty;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] min_value;
      logic [RUN_BITS-1:0]   refill_run;
      logic                  finished;
   } rsp_type;

   // One step of the minimum scan, aligned with the head RAM read data.
   typedef struct packed {
      logic step;
      logic first;
      logic last;
      logic vld;
   } scan_step_type;

   // Outcome of a completed scan.
   typedef struct packed {
      logic done;
      logic found;
   } scan_res_type;

endpackage

FILE: sv/kwm_head_ram.sv
module kwm_head_ram #(
   parameter int DEPTH = kwm_pkg::MAX_RUNS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [kwm_pkg::VALUE_BITS-1:0]  wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [kwm_pkg::VALUE_BITS-1:0]  rd_data
);

   logic [kwm_pkg::VALUE_BITS-1:0] mem_ff [DEPTH];
   logic [kwm_pkg::VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/kwm_min_scan.sv
module kwm_min_scan #(
   parameter int MAX_RUNS = kwm_pkg::MAX_RUNS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kwm_pkg::scan_step_type            step,
   input  logic [$clog2(MAX_RUNS)-1:0]       step_idx,
   input  logic [kwm_pkg::VALUE_BITS-1:0]    step_value,
   output kwm_pkg::scan_res_type             res,
   output logic [$clog2(MAX_RUNS)-1:0]       best_idx,
   output logic [kwm_pkg::VALUE_BITS-1:0]    best_value
);

   localparam int IDX_W = $clog2(MAX_RUNS);

   logic                           found_ff, found_in;
   logic                           done_ff, done_in;
   logic [IDX_W-1:0]               best_idx_ff, best_idx_in;
   logic [kwm_pkg::VALUE_BITS-1:0] best_value_ff, best_value_in;
   logic                           take;

   // The single comparator: a valid entry replaces the running best when none
   // is held yet or when strictly smaller, so ties keep the lower run index.
   always_comb begin
      take          = step.step && step.vld &&
                      (step.first || !found_ff || (step_value < best_value_ff));
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_value_in = best_value_ff;
      if (step.step && step.first) begin
         found_in = step.vld;
      end else if (step.step) begin
         found_in = found_ff || step.vld;
      end
      if (take) begin
         best_idx_in   = step_idx;
         best_value_in = step_value;
      end
      done_in = step.step && step.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         found_ff <= found_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_value_ff <= best_value_in;
   end

   assign res.done   = done_ff;
   assign res.found  = found_ff;
   assign best_idx   = best_idx_ff;
   assign best_value = best_value_ff;

endmodule

FILE: sv/k_way_merge_min_select.sv
// K-way merge minimum selector for the merge stage of an external sort.
// After reset, and after every finished merge, the block loads the first
// element of run 0, 1, 2 and so on, one request each, until csr run_count
// runs are loaded (0 counts as 1, values above MAX_RUNS count as MAX_RUNS).
// A load request that does not complete the load phase gives no response
// and never raises busy. The request that completes the load, and every
// later refill request, starts a linear scan: one shared comparator
// visits all MAX_RUNS head entries, one per cycle, through the single
// read port of the head RAM. The response strobe rsp_valid rises once the
// last entry has passed the registered RAM read data and step and then the
// registered scan result of the comparator, and busy drops in the cycle
// after the strobe. The response names the smallest valid
// head, the lowest run index winning ties, and the run that the next
// request must refill; that request either carries the run's next value or
// sets run_empty. When every run is empty the response has finished set,
// zero in its other fields, and the block returns to loading. The response
// is held on rsp_data for exactly one cycle and cannot be stalled, so the
// receiver must take it in its strobe cycle. Head values are kept in a RAM
// with no reset and no clearing pass; per-run valid bits decide which
// entries take part. Write run_count only while the block is idle.
module k_way_merge_min_select #(
   parameter int MAX_RUNS = kwm_pkg::MAX_RUNS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  kwm_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output kwm_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [kwm_pkg::CSR_BITS-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_RUNS);
   localparam int CNT_W = $clog2(MAX_RUNS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RUNS - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [kwm_pkg::CSR_BITS-1:0]   run_count_ff;
   logic                           loading_ff, loading_in;
   logic [CNT_W-1:0]               load_count_ff, load_count_in;
   logic [IDX_W-1:0]               pending_ff, pending_in;
   logic [MAX_RUNS-1:0]            head_valid_ff, head_valid_in;
   logic [IDX_W-1:0]               scan_idx_ff, scan_idx_in;
   kwm_pkg::scan_step_type         stp_ff, stp_in;
   logic [IDX_W-1:0]               stp_idx_ff;

   logic                           req_accept;
   logic [CNT_W-1:0]               active_runs;
   logic                           load_ok;
   logic [CNT_W-1:0]               load_count_nxt;
   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   logic                           rd_en;
   logic [kwm_pkg::VALUE_BITS-1:0] rd_data;
   kwm_pkg::scan_res_type          scan_res;
   logic [IDX_W-1:0]               best_idx;
   logic [kwm_pkg::VALUE_BITS-1:0] best_value;

   assign busy       = (state_ff != ST_IDLE);
   assign req_accept = start && !busy;

   // Effective run count, clamped into 1..MAX_RUNS.
   always_comb begin
      if (run_count_ff == '0) begin
         active_runs = CNT_W'(1);
      end else if (int'(run_count_ff) > MAX_RUNS) begin
         active_runs = CNT_W'(MAX_RUNS);
      end else begin
         active_runs = CNT_W'(run_count_ff);
      end
   end

   assign load_ok        = (load_count_ff < active_runs);
   assign load_count_nxt = load_ok ? (load_count_ff + CNT_W'(1)) : load_count_ff;

   // Head RAM write port: a load writes the next run in order, a refill
   // writes the run named by the last response. Empty runs only lose their
   // valid bit, so their entry is left alone.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pending_ff;
      if (req_accept && loading_ff) begin
         wr_en   = load_ok && !req_data.run_empty;
         wr_addr = load_count_ff[IDX_W-1:0];
      end else if (req_accept) begin
         wr_en   = !req_data.run_empty;
      end
   end

   assign rd_en = (state_ff == ST_SCAN);

   // Sequencer: accepts requests, walks the scan index over every head
   // entry, and applies the scan outcome when the result strobe fires.
   always_comb begin
      state_in      = state_ff;
      loading_in    = loading_ff;
      load_count_in = load_count_ff;
      pending_in    = pending_ff;
      head_valid_in = head_valid_ff;
      scan_idx_in   = scan_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && loading_ff) begin
               if (load_ok) begin
                  head_valid_in[load_count_ff[IDX_W-1:0]] = !req_data.run_empty;
               end
               load_count_in = load_count_nxt;
               if (load_count_nxt >= active_runs) begin
                  loading_in  = 1'b0;
                  state_in    = ST_SCAN;
                  scan_idx_in = '0;
               end
            end else if (req_accept) begin
               if (req_data.run_empty) begin
                  head_valid_in[pending_ff] = 1'b0;
               end
               state_in    = ST_SCAN;
               scan_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in    = ST_WAIT;
               scan_idx_in = '0;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_WAIT: begin
            if (scan_res.done) begin
               state_in = ST_IDLE;
               if (scan_res.found) begin
                  pending_in = best_idx;
               end else begin
                  loading_in    = 1'b1;
                  load_count_in = '0;
                  pending_in    = '0;
                  head_valid_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Scan step issued alongside each RAM read; it is registered so that it
   // lines up with the registered read data.
   always_comb begin
      stp_in.step  = (state_ff == ST_SCAN);
      stp_in.first = (scan_idx_ff == '0);
      stp_in.last  = (scan_idx_ff == LAST_IDX);
      stp_in.vld   = head_valid_ff[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_count_ff  <= kwm_pkg::RUN_COUNT_RESET;
         loading_ff    <= 1'b1;
         load_count_ff <= '0;
         pending_ff    <= '0;
         head_valid_ff <= '0;
         scan_idx_ff   <= '0;
         stp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         loading_ff    <= loading_in;
         load_count_ff <= load_count_in;
         pending_ff    <= pending_in;
         head_valid_ff <= head_valid_in;
         scan_idx_ff   <= scan_idx_in;
         stp_ff        <= stp_in;
         if (csr_we) begin
            run_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      stp_idx_ff <= scan_idx_ff;
   end

   kwm_head_ram #(
      .DEPTH (MAX_RUNS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   kwm_min_scan #(
      .MAX_RUNS (MAX_RUNS)
   ) u_min_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (stp_ff),
      .step_idx   (stp_idx_ff),
      .step_value (rd_data),
      .res        (scan_res),
      .best_idx   (best_idx),
      .best_value (best_value)
   );

   // The response is shown for the single cycle in which the scan
   // completes; a scan that found no valid head reports the end of merge.
   assign rsp_valid           = scan_res.done;
   assign rsp_data.finished   = !scan_res.found;
   assign rsp_data.min_value  = scan_res.found ? best_value : '0;
   assign rsp_data.refill_run = scan_res.found ? kwm_pkg::RUN_BITS'(best_idx) : '0;

   // A response only appears while the block still reports busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_WAIT))
      else $error("response strobe outside the scan wait state");

   // An accepted request never yields a response in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !rsp_valid)
      else $error("response too early after an accepted request");

   // A refill request always starts a scan.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !loading_ff) |=> (state_ff == ST_SCAN))
      else $error("refill request did not start a scan");

   // The run named for refill holds a valid head.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.finished) |=> head_valid_ff[pending_ff])
      else $error("refill run has no valid head");

   // A finished merge clears every head and returns to loading.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.finished) |=> (loading_ff && (head_valid_ff == '0)))
      else $error("finished merge left stale state");

endmodule

FILE: dv/tb_top.sv
module tb_top;

   localparam int MAX_RUNS_DEFAULT = kwm_pkg::MAX_RUNS_DEFAULT;
   localparam int VALUE_BITS       = kwm_pkg::VALUE_BITS;
   localparam int RUN_BITS         = kwm_pkg::RUN_BITS;
   localparam int CSR_BITS         = kwm_pkg::CSR_BITS;
   localparam logic [CSR_BITS-1:0] RUN_COUNT_RESET = kwm_pkg::RUN_COUNT_RESET;

   typedef kwm_pkg::req_type req_type;
   typedef kwm_pkg::rsp_type rsp_type;

   // The block is built with its default of 16 head entries.
   localparam int HEADS      = MAX_RUNS_DEFAULT;
   // A response is strobed when the scan of its request ends, and busy drops
   // in the cycle after the strobe. The SETTLE wait lets a scan that was started
   // by the last request run out before the run count is touched.
   localparam int SETTLE     = HEADS + 6;
   localparam int ITEM_GOAL  = 1250;
   // The final CALM_TAIL requests are sent without random idle gaps.
   localparam int CALM_TAIL  = 150;
   // Longest sorted run that the stimulus builds.
   localparam int RUN_DEPTH  = 8;

   localparam logic [VALUE_BITS-1:0] TOP_VALUE = VALUE_BITS'(999999999);
   localparam logic [VALUE_BITS-1:0] ABOVE_TOP = VALUE_BITS'(1000000000);
   localparam logic [VALUE_BITS-1:0] ALL_ONES  = '1;

   localparam rsp_type NO_RSP     = '0;
   localparam rsp_type FINISH_RSP = '{min_value: '0, refill_run: '0, finished: 1'b1};

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;
   typedef enum logic [1:0] {FEED_CLEAN, FEED_BROKEN, FEED_NOISE} feed_mode_type;
   typedef enum logic [1:0] {STYLE_WIDE, STYLE_NARROW, STYLE_EDGE} value_style_type;

   // One row of the directed part: either a run_count write or a request.
   // Where typed is set, the response is spelled out in the row and it is
   // expected in place of the predicted one.
   typedef struct packed {
      row_kind_type        kind;
      logic [CSR_BITS-1:0] csr;
      req_type             req;
      logic                typed;
      rsp_type             rsp;
   } step_row_type;

   // The directed part walks the special cases by hand:
   // - the reset run count of 10 with every run loaded empty, so the last
   //   load request yields the finished response at once;
   // - a run count of zero, which behaves as one run, with the top value;
   // - two runs holding the largest 30-bit value and zero, then a tie on
   //   the largest value that the lower run index wins;
   // - a run count lowered while loading, which makes the next request
   //   close the load phase without storing its value.
   localparam step_row_type DIRECTED_STEPS [26] = '{
      '{ROW_REQ, 5'd0,  '{ALL_ONES, 1'b1},      1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{ALL_ONES, 1'b1},      1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{ALL_ONES, 1'b1},      1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{ALL_ONES, 1'b1},      1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{ALL_ONES, 1'b1},      1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{ALL_ONES, 1'b1},      1'b1, FINISH_RSP},
      '{ROW_CSR, 5'd0,  '{'0, 1'b0},            1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{TOP_VALUE, 1'b0},     1'b1, '{TOP_VALUE, 4'd0, 1'b0}},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b1, FINISH_RSP},
      '{ROW_CSR, 5'd2,  '{'0, 1'b0},            1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{ALL_ONES, 1'b0},      1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{'0, 1'b0},            1'b1, '{'0, 4'd1, 1'b0}},
      '{ROW_REQ, 5'd0,  '{ALL_ONES, 1'b0},      1'b1, '{ALL_ONES, 4'd0, 1'b0}},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b1, '{ALL_ONES, 4'd1, 1'b0}},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b1, FINISH_RSP},
      '{ROW_CSR, 5'd3,  '{'0, 1'b0},            1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{30'd7, 1'b0},         1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{30'd5, 1'b0},         1'b0, NO_RSP},
      '{ROW_CSR, 5'd1,  '{'0, 1'b0},            1'b0, NO_RSP},
      '{ROW_REQ, 5'd0,  '{30'd100, 1'b0},       1'b1, '{30'd5, 4'd1, 1'b0}},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b1, '{30'd7, 4'd0, 1'b0}},
      '{ROW_REQ, 5'd0,  '{'0, 1'b1},            1'b1, FINISH_RSP}
   };

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_type             req_data  = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [CSR_BITS-1:0] csr_wdata = '0;

   // Shadow of the merge state, advanced once per accepted request.
   logic [VALUE_BITS-1:0] head_value [HEADS];
   logic [HEADS-1:0]      head_live     = '0;
   bit                    in_load       = 1'b1;
   int unsigned           loaded_runs   = 0;
   int unsigned           refill_target = 0;
   logic [CSR_BITS-1:0]   run_count_q   = RUN_COUNT_RESET;

   // Sorted runs that well-formed merges draw their requests from.
   logic [VALUE_BITS-1:0] run_stock [HEADS][RUN_DEPTH];
   int unsigned           stock_len [HEADS];
   int unsigned           stock_pos [HEADS];

   // Responses still owed by the block, oldest first.
   rsp_type expected_picks [$];

   rsp_type     last_pick;
   bit          last_made      = 1'b0;
   int          idle_pct       = 0;
   int          requests_sent  = 0;
   int          responses_seen = 0;
   int          finishes_seen  = 0;
   int          csr_writes     = 0;
   int          error_count    = 0;

   k_way_merge_min_select u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advances the shadow state by one accepted request. Returns 1 when the
   // request yields a response, and that response in pick.
   function automatic bit merge_select_step(input req_type item, output rsp_type pick);
      int unsigned           span;
      bit                    found;
      int unsigned           best;
      logic [VALUE_BITS-1:0] best_value;
      pick = '0;
      // Zero behaves as one run and anything past the head count as all heads.
      span = (run_count_q == 0) ? 1 : ((run_count_q > HEADS) ? HEADS : run_count_q);
      if (in_load) begin
         // Once the load count has reached a run count that was lowered while
         // loading, the request is not stored but still closes the load.
         if (loaded_runs < span) begin
            head_value[loaded_runs] = item.run_empty ? '0 : item.value;
            head_live[loaded_runs]  = !item.run_empty;
            loaded_runs++;
         end
         if (loaded_runs < span)
            return 1'b0;
         in_load = 1'b0;
      end else if (item.run_empty) begin
         head_live[refill_target] = 1'b0;
      end else begin
         head_value[refill_target] = item.value;
      end
      // Strict less-than keeps the lowest run index on ties.
      found      = 1'b0;
      best       = 0;
      best_value = '0;
      for (int i = 0; i < HEADS; i++) begin
         if (head_live[i] && (!found || head_value[i] < best_value)) begin
            found      = 1'b1;
            best       = i;
            best_value = head_value[i];
         end
      end
      if (found) begin
         refill_target   = best;
         pick.min_value  = best_value;
         pick.refill_run = RUN_BITS'(best);
      end else begin
         // Every run is exhausted: report it and start loading again.
         in_load       = 1'b1;
         loaded_runs   = 0;
         refill_target = 0;
         head_live     = '0;
         pick.finished = 1'b1;
      end
      return 1'b1;
   endfunction

   // Builds a fresh set of ascending runs. Most runs are short; now and then
   // one is empty from the start or goes to the full depth.
   function automatic void stock_runs();
      value_style_type       style;
      logic [VALUE_BITS-1:0] v;
      int unsigned           j;
      style = value_style_type'($urandom_range(2));
      for (int r = 0; r < HEADS; r++) begin
         stock_len[r] = ($urandom_range(7) == 0) ? $urandom_range(RUN_DEPTH) :
                                                   $urandom_range(3);
         stock_pos[r] = 0;
         for (int k = 0; k < stock_len[r]; k++) begin
            case (style)
               STYLE_NARROW: begin
                  v = VALUE_BITS'($urandom_range(3));
               end
               STYLE_EDGE: begin
                  case ($urandom_range(3))
                     0:       v = '0;
                     1:       v = TOP_VALUE;
                     2:       v = ABOVE_TOP;
                     default: v = ALL_ONES;
                  endcase
               end
               default: begin
                  v = VALUE_BITS'($urandom);
               end
            endcase
            // Insertion keeps the run in ascending order.
            j = k;
            while (j > 0 && run_stock[r][j-1] > v) begin
               run_stock[r][j] = run_stock[r][j-1];
               j--;
            end
            run_stock[r][j] = v;
         end
      end
   endfunction

   function automatic req_type noise_request();
      req_type item;
      item.value     = VALUE_BITS'($urandom);
      item.run_empty = ($urandom_range(2) == 0);
      return item;
   endfunction

   // Next request of a well-formed merge: the first element of the next run
   // while loading, otherwise the next element of the run named for refill.
   // A run with nothing left is reported empty, with random ignored bits.
   function automatic req_type feed_request();
      req_type     item;
      int unsigned slot;
      slot = in_load ? loaded_runs : refill_target;
      if (slot >= HEADS)
         slot = 0;
      if (stock_pos[slot] < stock_len[slot]) begin
         item.value     = run_stock[slot][stock_pos[slot]];
         item.run_empty = 1'b0;
         stock_pos[slot]++;
      end else begin
         item.value     = VALUE_BITS'($urandom);
         item.run_empty = 1'b1;
      end
      return item;
   endfunction

   function automatic logic [CSR_BITS-1:0] pick_run_count();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return CSR_BITS'(HEADS);
         3:       return CSR_BITS'($urandom_range(31, HEADS + 1));
         4, 5:    return CSR_BITS'($urandom_range(2, 1));
         default: return CSR_BITS'($urandom_range(8, 2));
      endcase
   endfunction

   // Presents one request, holds it until the block takes it, and records
   // what the block owes for it. A typed response replaces the prediction.
   // The caller either follows up in the same step or lowers start.
   task automatic issue_request(input req_type item, input bit typed,
                                input rsp_type typed_rsp);
      rsp_type pick;
      bit      made;
      if (requests_sent < ITEM_GOAL - CALM_TAIL && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      requests_sent++;
      made = merge_select_step(item, pick);
      if (typed)
         expected_picks = {expected_picks, typed_rsp};
      else if (made)
         expected_picks = {expected_picks, pick};
      last_made = made;
      last_pick = pick;
   endtask

   // The run count is only written with the block quiet: every owed
   // response has arrived and any scan still in flight has had time to end.
   task automatic write_run_count(input logic [CSR_BITS-1:0] count);
      start <= 1'b0;
      while (expected_picks.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we      <= 1'b0;
      run_count_q = count;
      csr_writes++;
   endtask

   function automatic void flag_error(input string what, input rsp_type want,
                                      input rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display("%0t %s: expected value=%0d run=%0d finished=%0b, %s",
                  $time, what, want.min_value, want.refill_run, want.finished,
                  $sformatf("got value=%0d run=%0d finished=%0b",
                            got.min_value, got.refill_run, got.finished));
   endfunction

   // The response is strobed for one cycle only, so it is taken at the
   // edge that closes its strobe cycle and checked against the oldest
   // expectation, field by field.
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid) begin
         responses_seen++;
         if (rsp_data.finished === 1'b1)
            finishes_seen++;
         if (expected_picks.size() == 0) begin
            flag_error("response with no request owing one", NO_RSP, rsp_data);
         end else begin
            want = expected_picks.pop_front();
            if (rsp_data.min_value !== want.min_value || rsp_data.refill_run !== want.refill_run ||
                rsp_data.finished !== want.finished)
               flag_error("response mismatch", want, rsp_data);
         end
      end
   end

   initial begin : stimulus
      feed_mode_type mode;
      req_type       item;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 20;
      for (int s = 0; s < $size(DIRECTED_STEPS); s++) begin
         if (DIRECTED_STEPS[s].kind == ROW_CSR)
            write_run_count(DIRECTED_STEPS[s].csr);
         else
            issue_request(DIRECTED_STEPS[s].req, DIRECTED_STEPS[s].typed, DIRECTED_STEPS[s].rsp);
      end

      // Random part: mostly whole merges of ascending runs, some merges with
      // stray requests mixed in, and some bursts of pure noise. The run count
      // moves between merges and now and then in the middle of one, both
      // while loading and while merging.
      while (requests_sent < ITEM_GOAL) begin
         case ($urandom_range(2))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            default: idle_pct = 40;
         endcase
         if ($urandom_range(2) == 0)
            write_run_count(pick_run_count());
         case ($urandom_range(19))
            0, 1, 2: mode = FEED_BROKEN;
            3, 4:    mode = FEED_NOISE;
            default: mode = FEED_CLEAN;
         endcase
         if (mode == FEED_NOISE) begin
            repeat ($urandom_range(30, 5))
               issue_request(noise_request(), 1'b0, NO_RSP);
         end else begin
            stock_runs();
            do begin
               if ($urandom_range(49) == 0)
                  write_run_count(pick_run_count());
               item = feed_request();
               if (mode == FEED_BROKEN && $urandom_range(7) == 0)
                  item = noise_request();
               issue_request(item, 1'b0, NO_RSP);
            end while (!(last_made && last_pick.finished));
         end
      end
      start <= 1'b0;

      // Drain the owed responses, then watch a little longer for strays.
      while (expected_picks.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Run covered %0d requests, %0d responses (%0d finished merges),",
               requests_sent, responses_seen, finishes_seen);
      $display("with %0d run_count writes between and inside merges.", csr_writes);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
sv/kwm_pkg.sv
sv/kwm_head_ram.sv
sv/kwm_min_scan.sv
sv/k_way_merge_min_select.sv
dv/tb_top.sv
